[hw/rtl/dljq_pkg.sv]
package dljq_pkg;

  localparam int DEPTH_DEF = 16;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 8;
  localparam int TIME_W = 64;
  localparam int STAT_W = 3;

  localparam int IN_W  = 80;  // 75 payload bits padded to bytes
  localparam int OUT_W = 16;  // 14 payload bits padded to bytes

  localparam logic [FUNC_W-1:0] FUNC_ENQ    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_CANCEL = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DONE   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_KILL   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_STOPPED = 3'd1;
  localparam logic [STAT_W-1:0] ST_DUP     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFND  = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic load;  // capture request
    logic exec;  // apply the function
    logic disp;  // dispatch check
  } dljq_cmd_t;

endpackage

[hw/rtl/dljq_ctrl.sv]
module dljq_ctrl
  import dljq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_ready,
  output logic      in_ready,
  output logic      out_valid,
  output dljq_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DISP = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_fire) state_next = S_EXEC;
      S_EXEC: state_next = S_DISP;
      S_DISP: state_next = S_RESP;
      S_RESP: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_RESP);
  assign cmd.load  = in_fire;
  assign cmd.exec  = (state == S_EXEC);
  assign cmd.disp  = (state == S_DISP);

endmodule

[hw/rtl/dljq_datapath.sv]
module dljq_datapath
  import dljq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  dljq_cmd_t         cmd,
  input  logic [IN_W-1:0]   in_data,
  output logic [OUT_W-1:0]  out_data,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // request
  logic [FUNC_W-1:0] req_func;
  logic [ID_W-1:0]   req_id;
  logic [TIME_W-1:0] req_due;

  // sorted queue, entry 0 is the head
  logic [TIME_W-1:0] slot_time [QUEUE_DEPTH];
  logic [ID_W-1:0]   slot_job  [QUEUE_DEPTH];
  logic [TIME_W-1:0] time_next [QUEUE_DEPTH];
  logic [ID_W-1:0]   job_next  [QUEUE_DEPTH];
  logic [CW-1:0]     count_next;

  logic              busy, stopped;
  logic [ID_W-1:0]   busy_job;
  logic [TIME_W-1:0] now_ms;

  logic [STAT_W-1:0] status;
  logic              is_queued, is_running, disp_valid;
  logic [ID_W-1:0]   disp_id;

  logic [QUEUE_DEPTH-1:0] live, match, le, prev_le, after;
  logic [TIME_W-1:0] ins_time;
  logic found, running, do_ins, do_rem, disp_ok, do_pop;

  assign ins_time = (req_due == '0) ? now_ms : req_due;
  assign running  = busy && (busy_job == req_id);

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      live[i]  = CW'(i) < count;
      match[i] = live[i] && (slot_job[i] == req_id);
      le[i]    = live[i] && (slot_time[i] <= ins_time);
    end
    prev_le[0] = 1'b1;
    after[0]   = match[0];
    for (int i = 1; i < QUEUE_DEPTH; i++) begin
      prev_le[i] = le[i-1];
      after[i]   = after[i-1] | match[i];
    end
  end

  assign found   = |match;
  assign do_ins  = cmd.exec && (req_func == FUNC_ENQ) && !stopped && !found
                   && (count != CW'(QUEUE_DEPTH));
  assign do_rem  = cmd.exec && (req_func == FUNC_CANCEL) && found;
  assign disp_ok = !stopped && !busy && (count != '0) && (slot_time[0] <= now_ms);
  assign do_pop  = cmd.disp && disp_ok;

  // per-entry shift: up on insert, down on remove or pop
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      time_next[i] = slot_time[i];
      job_next[i]  = slot_job[i];
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (do_ins && !le[i]) begin
        if (prev_le[i]) begin
          time_next[i] = ins_time;
          job_next[i]  = req_id;
        end else if (i > 0) begin
          time_next[i] = slot_time[(i > 0) ? i - 1 : 0];
          job_next[i]  = slot_job[(i > 0) ? i - 1 : 0];
        end
      end else if ((do_rem && after[i]) || do_pop) begin
        if (i < QUEUE_DEPTH - 1) begin
          time_next[i] = slot_time[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
          job_next[i]  = slot_job[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        end
      end
    end
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_rem || do_pop) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      slot_time[i] <= time_next[i];
      slot_job[i]  <= job_next[i];
    end
    if (cmd.load) begin
      req_func <= in_data[FUNC_W-1:0];
      req_id   <= in_data[FUNC_W +: ID_W];
      req_due  <= in_data[FUNC_W+ID_W +: TIME_W];
    end
    if (cmd.exec) begin
      status     <= ST_OK;
      is_queued  <= 1'b0;
      is_running <= 1'b0;
      unique case (req_func)
        FUNC_ENQ: begin
          if (stopped)                         status <= ST_STOPPED;
          else if (found)                      status <= ST_DUP;
          else if (count == CW'(QUEUE_DEPTH))  status <= ST_FULL;
        end
        FUNC_CANCEL: begin
          is_running <= running;
          if (!found && !running) status <= ST_NOTFND;
        end
        FUNC_QUERY: begin
          is_queued  <= found;
          is_running <= running;
        end
        default: ;
      endcase
    end
    if (cmd.disp) begin
      disp_valid <= disp_ok;
      disp_id    <= disp_ok ? slot_job[0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      busy     <= 1'b0;
      busy_job <= '0;
      stopped  <= 1'b0;
      now_ms   <= '0;
    end else begin
      count <= count_next;
      if (cmd.exec) begin
        unique case (req_func)
          FUNC_TICK: now_ms <= now_ms + TIME_W'(1);
          FUNC_DONE: begin
            busy     <= 1'b0;
            busy_job <= '0;
          end
          FUNC_KILL: stopped <= 1'b1;
          default: ;
        endcase
      end
      if (do_pop) begin
        busy     <= 1'b1;
        busy_job <= slot_job[0];
      end
    end
  end

  assign out_data = {2'b00, disp_id, disp_valid, is_running, is_queued, status};

endmodule

[hw/rtl/deadline_job_queue_unit.sv]
// Deadline job queue: keeps up to QUEUE_DEPTH job ids sorted by due time
// (ties keep arrival order) and feeds a single running slot from the head.
// Each request on s_* (enqueue, cancel, query, tick, done, kill) gives
// exactly one response on m_*. The queue is a row of entry registers that
// insert or remove by shifting all entries at once, and the controller walks
// capture, execute, dispatch check and respond, taking the next request
// only after the response is taken.
module deadline_job_queue_unit
  import dljq_pkg::*;
#(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // func[2:0], job_id[10:3], due_time[74:11]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // status[2:0], is_queued[3], is_running[4],
                                      // dispatch_valid[5], dispatch_id[13:6]
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  dljq_cmd_t     cmd;
  logic          in_fire;
  logic [CW-1:0] count;

  assign in_fire = s_tvalid && s_tready;

  dljq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .out_ready (m_tready),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .cmd       (cmd)
  );

  dljq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (s_tdata),
    .out_data (m_tdata),
    .count    (count)
  );

  // one request in flight at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !s_tready) else $error("request taken while busy");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready)) else $error("response and request overlap");

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");

  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[2:0] <= ST_FULL)) else $error("bad status code");

endmodule
